/* design/qbri_pkg.sv */
// ----------------------------------------------------------------------------
// qbri_pkg
// Shared constants and control types of the quaternion body-rate integrator.
// ----------------------------------------------------------------------------
package qbri_pkg;

  localparam int QUAT_WIDTH_DEF  = 16;
  localparam int RATE_WIDTH_DEF  = 16;
  localparam int STEP_WIDTH      = 16;
  localparam logic [STEP_WIDTH-1:0] STEP_RESET = 16'd655;

  // integer bits of the rate format (Q4.x)
  localparam int RATE_INT_BITS   = 4;
  // 16 fraction bits of the step plus one for the factor one half
  localparam int STEP_FRAC_EXTRA = 17;

  typedef struct packed {
    logic vld;
    logic degen;
  } ctl_t;

endpackage

/* design/qbri_step.sv */
// ----------------------------------------------------------------------------
// qbri_step
// Euler step: kinematic products, q_dot sums, step-time scaling, rounding and
// saturation to Q2.14. Seven register stages, result as sign and magnitude.
// ----------------------------------------------------------------------------
module qbri_step #(
  parameter int QUAT_WIDTH = qbri_pkg::QUAT_WIDTH_DEF,
  parameter int RATE_WIDTH = qbri_pkg::RATE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic signed [QUAT_WIDTH-1:0]        in_quat [4],
  input  logic signed [RATE_WIDTH-1:0]        in_rate [3],
  input  logic [qbri_pkg::STEP_WIDTH-1:0]     step_time,
  output logic                                out_vld,
  output logic                                out_neg [4],
  output logic [QUAT_WIDTH-1:0]               out_mag [4]
);

  localparam int PW  = QUAT_WIDTH + RATE_WIDTH;
  localparam int SW  = PW + 2;
  localparam int MW  = SW + qbri_pkg::STEP_WIDTH + 1;
  localparam int SS  = RATE_WIDTH - qbri_pkg::RATE_INT_BITS + qbri_pkg::STEP_FRAC_EXTRA;
  localparam int CW  = QUAT_WIDTH + SS;
  localparam int TW  = ((CW > MW) ? CW : MW) + 1;
  localparam int RDW = TW - SS + 1;

  // operand selection: component i = +t0 +t1 -t2 (component 0: -t0 -t1 -t2)
  localparam int QSEL [4][3] = '{'{1, 2, 3}, '{0, 2, 3}, '{0, 3, 1}, '{0, 1, 2}};
  localparam int RSEL [4][3] = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2}, '{2, 1, 0}};

  logic [6:0]                  vld_r;
  logic signed [QUAT_WIDTH-1:0] q1_r [4];
  logic signed [QUAT_WIDTH-1:0] q2_r [4];
  logic signed [QUAT_WIDTH-1:0] q3_r [4];
  logic signed [QUAT_WIDTH-1:0] q4_r [4];
  logic signed [RATE_WIDTH-1:0] r1_r [3];
  logic signed [PW-1:0]        pr2_r [4][3];
  logic signed [SW-1:0]        sum3_r [4];
  logic signed [MW-1:0]        mul4_r [4];
  logic signed [TW-1:0]        tot5_r [4];
  logic                        neg6_r [4];
  logic [TW-1:0]               abs6_r [4];
  logic                        neg7_r [4];
  logic [QUAT_WIDTH-1:0]       mag7_r [4];

  logic signed [SW-1:0]        sum_nxt [4];
  logic [TW:0]                 half_w [4];
  logic [RDW-1:0]              rnd_w [4];
  logic [RDW-1:0]              lim_w [4];
  logic [QUAT_WIDTH-1:0]       mag_nxt [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i == 0) begin
        sum_nxt[i] = -(SW'(pr2_r[i][0]) + SW'(pr2_r[i][1]) + SW'(pr2_r[i][2]));
      end else begin
        sum_nxt[i] = SW'(pr2_r[i][0]) + SW'(pr2_r[i][1]) - SW'(pr2_r[i][2]);
      end
      // round half away from zero on the magnitude, then clamp
      half_w[i]  = {1'b0, abs6_r[i]} + ((TW+1)'(1) << (SS - 1));
      rnd_w[i]   = half_w[i][TW:SS];
      lim_w[i]   = neg6_r[i] ? (RDW'(1) << (QUAT_WIDTH - 1))
                             : ((RDW'(1) << (QUAT_WIDTH - 1)) - RDW'(1));
      mag_nxt[i] = (rnd_w[i] > lim_w[i]) ? lim_w[i][QUAT_WIDTH-1:0]
                                         : rnd_w[i][QUAT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      q1_r[i]   <= in_quat[i];
      q2_r[i]   <= q1_r[i];
      q3_r[i]   <= q2_r[i];
      q4_r[i]   <= q3_r[i];
      for (int j = 0; j < 3; j++) begin
        pr2_r[i][j] <= q1_r[QSEL[i][j]] * r1_r[RSEL[i][j]];
      end
      sum3_r[i] <= sum_nxt[i];
      mul4_r[i] <= MW'(sum3_r[i]) * $signed({1'b0, step_time});
      tot5_r[i] <= (TW'(q4_r[i]) <<< SS) + TW'(mul4_r[i]);
      neg6_r[i] <= tot5_r[i][TW-1];
      abs6_r[i] <= tot5_r[i][TW-1] ? TW'(-tot5_r[i]) : TW'(tot5_r[i]);
      neg7_r[i] <= neg6_r[i];
      mag7_r[i] <= mag_nxt[i];
    end
    for (int j = 0; j < 3; j++) begin
      r1_r[j] <= in_rate[j];
    end
  end

  assign out_vld = vld_r[6];
  assign out_neg = neg7_r;
  assign out_mag = mag7_r;

endmodule

/* design/qbri_div.sv */
// ----------------------------------------------------------------------------
// qbri_div
// Squares, squared norm and a radix-2 restoring divider pipeline giving
// floor(c^2 * 2^(2*QW-2) / |c|^2) per component, one quotient bit a stage.
// ----------------------------------------------------------------------------
module qbri_div #(
  parameter int QUAT_WIDTH = qbri_pkg::QUAT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic                      in_neg [4],
  input  logic [QUAT_WIDTH-1:0]     in_mag [4],
  output qbri_pkg::ctl_t            out_ctl,
  output logic                      out_neg [4],
  output logic [2*QUAT_WIDTH-2:0]   out_quo [4]
);

  localparam int SQW = 2 * QUAT_WIDTH;
  localparam int NW  = 2 * QUAT_WIDTH + 1;
  localparam int QB  = 2 * QUAT_WIDTH - 1;

  logic                 vlda_r;
  logic                 nega_r [4];
  logic [SQW-1:0]       sqa_r [4];
  logic [NW-1:0]        n2_nxt;

  qbri_pkg::ctl_t       ctl_r  [QB+1];
  logic                 neg_r  [QB+1][4];
  logic [QB-1:0]        quo_r  [QB+1][4];
  logic [NW-1:0]        rem_r  [QB][4];
  logic [NW-1:0]        n2_r   [QB];
  logic                 lsb_r  [4];

  assign n2_nxt = NW'(sqa_r[0]) + NW'(sqa_r[1]) + NW'(sqa_r[2]) + NW'(sqa_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlda_r       <= 1'b0;
      ctl_r[0]     <= '0;
    end else begin
      vlda_r       <= in_vld;
      ctl_r[0].vld   <= vlda_r;
      ctl_r[0].degen <= (n2_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      nega_r[i]   <= in_neg[i];
      sqa_r[i]    <= SQW'(in_mag[i]) * SQW'(in_mag[i]);
      neg_r[0][i] <= nega_r[i];
      // top dividend bits form the first partial remainder
      rem_r[0][i] <= NW'(sqa_r[i] >> 1);
      lsb_r[i]    <= sqa_r[i][0];
      quo_r[0][i] <= '0;
    end
    n2_r[0] <= n2_nxt;
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [NW:0] trial_w [4];
    logic        ge_w    [4];

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        if (k == 0) begin
          trial_w[i] = {rem_r[k][i], lsb_r[i]};
        end else begin
          trial_w[i] = {rem_r[k][i], 1'b0};
        end
        ge_w[i] = (trial_w[i] >= {1'b0, n2_r[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 4; i++) begin
        neg_r[k+1][i] <= neg_r[k][i];
        quo_r[k+1][i] <= {quo_r[k][i][QB-2:0], ge_w[i]};
      end
    end

    if (k < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        for (int i = 0; i < 4; i++) begin
          rem_r[k+1][i] <= ge_w[i] ? NW'(trial_w[i] - {1'b0, n2_r[k]}) : NW'(trial_w[i]);
        end
        n2_r[k+1] <= n2_r[k];
      end
    end
  end

  assign out_ctl = ctl_r[QB];
  assign out_neg = neg_r[QB];
  assign out_quo = quo_r[QB];

endmodule

/* design/qbri_sqrt.sv */
// ----------------------------------------------------------------------------
// qbri_sqrt
// Digit-by-digit integer square root pipeline, one result bit a stage, then
// half-up rounding, sign restore and the identity override for zero norm.
// ----------------------------------------------------------------------------
module qbri_sqrt #(
  parameter int QUAT_WIDTH = qbri_pkg::QUAT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qbri_pkg::ctl_t                in_ctl,
  input  logic                          in_neg [4],
  input  logic [2*QUAT_WIDTH-2:0]       in_quo [4],
  output logic                          out_vld,
  output logic                          out_degen,
  output logic signed [QUAT_WIDTH-1:0]  out_next [4]
);

  localparam int QB = 2 * QUAT_WIDTH - 1;
  localparam int SI = QUAT_WIDTH;

  qbri_pkg::ctl_t              ctl_r [SI+1];
  logic                        neg_r [SI+1][4];
  logic [QB-1:0]               v_r   [SI+1][4];
  logic [QB-1:0]               res_r [SI+1][4];

  logic                        vld_r;
  logic                        degen_r;
  logic signed [QUAT_WIDTH-1:0] next_r [4];
  logic [QUAT_WIDTH:0]         rnd_w  [4];
  logic [QUAT_WIDTH-1:0]       half_w [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      neg_r[0][i] <= in_neg[i];
      v_r[0][i]   <= in_quo[i];
      res_r[0][i] <= '0;
    end
  end

  for (genvar j = 0; j < SI; j++) begin : g_sqrt
    localparam logic [QB-1:0] BIT = QB'(1) << (QB - 1 - 2 * j);
    logic [QB:0] sum_w [4];
    logic        ge_w  [4];

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        sum_w[i] = {1'b0, res_r[j][i]} + {1'b0, BIT};
        ge_w[i]  = ({1'b0, v_r[j][i]} >= sum_w[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j+1] <= '0;
      end else begin
        ctl_r[j+1] <= ctl_r[j];
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 4; i++) begin
        neg_r[j+1][i] <= neg_r[j][i];
        v_r[j+1][i]   <= ge_w[i] ? QB'(v_r[j][i] - sum_w[i][QB-1:0]) : v_r[j][i];
        res_r[j+1][i] <= ge_w[i] ? QB'((res_r[j][i] >> 1) + BIT) : (res_r[j][i] >> 1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rnd_w[i]  = (QUAT_WIDTH+1)'(res_r[SI][i][QUAT_WIDTH-1:0]) + (QUAT_WIDTH+1)'(1);
      half_w[i] = rnd_w[i][QUAT_WIDTH:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl_r[SI].vld;
    end
  end

  always_ff @(posedge clk) begin
    degen_r <= ctl_r[SI].degen;
    for (int i = 0; i < 4; i++) begin
      if (ctl_r[SI].degen) begin
        next_r[i] <= (i == 0) ? (QUAT_WIDTH'(1) << (QUAT_WIDTH - 2)) : '0;
      end else begin
        next_r[i] <= neg_r[SI][i] ? -$signed(half_w[i]) : $signed(half_w[i]);
      end
    end
  end

  assign out_vld   = vld_r;
  assign out_degen = degen_r;
  assign out_next  = next_r;

endmodule

/* design/quaternion_body_rate_integrator_core.sv */
// ----------------------------------------------------------------------------
// quaternion_body_rate_integrator_core
// One forward Euler step of quaternion kinematics followed by renormalization.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive in_quat_* (Q2.14) and in_rate_* (Q4.12 rad/s) with
//   start high; the beat is taken at the clock edge where start is high and
//   busy is low. busy is always low: a new beat may enter every cycle.
//   Result beat: out_valid is high for exactly one cycle with out_next_*
//   (normalized Q2.14) and out_degenerate; results leave in input order.
//   The receiver has no back-pressure and must take each beat as shown.
//   Throughput is one beat per cycle. A beat passes the seven-stage Euler
//   step, then the divider pipeline (one quotient bit per stage,
//   2*QUAT_WIDTH-1 stages) and then the square root pipeline (one root
//   bit per stage, QUAT_WIDTH stages).
//   Configuration: cfg_we writes cfg_wdata into step_time (Q0.16 s); write
//   only while no beat is in flight. Reset (synchronous, rst_n low) sets
//   step_time to 655 and empties the pipeline; no result beat is produced
//   for anything in flight at reset.
// ----------------------------------------------------------------------------
module quaternion_body_rate_integrator_core #(
  parameter int QUAT_WIDTH = qbri_pkg::QUAT_WIDTH_DEF,
  parameter int RATE_WIDTH = qbri_pkg::RATE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input beat
  input  logic                              start,
  output logic                              busy,
  input  logic signed [QUAT_WIDTH-1:0]      in_quat_w,
  input  logic signed [QUAT_WIDTH-1:0]      in_quat_x,
  input  logic signed [QUAT_WIDTH-1:0]      in_quat_y,
  input  logic signed [QUAT_WIDTH-1:0]      in_quat_z,
  input  logic signed [RATE_WIDTH-1:0]      in_rate_roll,
  input  logic signed [RATE_WIDTH-1:0]      in_rate_pitch,
  input  logic signed [RATE_WIDTH-1:0]      in_rate_yaw,
  // result beat
  output logic                              out_valid,
  output logic signed [QUAT_WIDTH-1:0]      out_next_w,
  output logic signed [QUAT_WIDTH-1:0]      out_next_x,
  output logic signed [QUAT_WIDTH-1:0]      out_next_y,
  output logic signed [QUAT_WIDTH-1:0]      out_next_z,
  output logic                              out_degenerate,
  // configuration
  input  logic                              cfg_we,
  input  logic [qbri_pkg::STEP_WIDTH-1:0]   cfg_wdata
);

  localparam int QB = 2 * QUAT_WIDTH - 1;

  logic [qbri_pkg::STEP_WIDTH-1:0] step_time_r;

  logic                         accept;
  logic signed [QUAT_WIDTH-1:0] quat_w [4];
  logic signed [RATE_WIDTH-1:0] rate_w [3];

  logic                         step_vld;
  logic                         step_neg [4];
  logic [QUAT_WIDTH-1:0]        step_mag [4];

  qbri_pkg::ctl_t               div_ctl;
  logic                         div_neg [4];
  logic [QB-1:0]                div_quo [4];

  logic signed [QUAT_WIDTH-1:0] next_w [4];

  // fully pipelined, never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign quat_w[0] = in_quat_w;
  assign quat_w[1] = in_quat_x;
  assign quat_w[2] = in_quat_y;
  assign quat_w[3] = in_quat_z;
  assign rate_w[0] = in_rate_roll;
  assign rate_w[1] = in_rate_pitch;
  assign rate_w[2] = in_rate_yaw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= qbri_pkg::STEP_RESET;
    end else if (cfg_we) begin
      step_time_r <= cfg_wdata;
    end
  end

  // Euler step, round and saturate to Q2.14
  qbri_step #(
    .QUAT_WIDTH (QUAT_WIDTH),
    .RATE_WIDTH (RATE_WIDTH)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (accept),
    .in_quat   (quat_w),
    .in_rate   (rate_w),
    .step_time (step_time_r),
    .out_vld   (step_vld),
    .out_neg   (step_neg),
    .out_mag   (step_mag)
  );

  // squared norm and c_i^2 / |c|^2 quotients
  qbri_div #(
    .QUAT_WIDTH (QUAT_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (step_vld),
    .in_neg  (step_neg),
    .in_mag  (step_mag),
    .out_ctl (div_ctl),
    .out_neg (div_neg),
    .out_quo (div_quo)
  );

  // root of each quotient gives |c_i| / |c|
  qbri_sqrt #(
    .QUAT_WIDTH (QUAT_WIDTH)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (div_ctl),
    .in_neg    (div_neg),
    .in_quo    (div_quo),
    .out_vld   (out_valid),
    .out_degen (out_degenerate),
    .out_next  (next_w)
  );

  assign out_next_w = next_w[0];
  assign out_next_x = next_w[1];
  assign out_next_y = next_w[2];
  assign out_next_z = next_w[3];

endmodule

/* design/qbri_checker.sv */
// ----------------------------------------------------------------------------
// qbri_checker
// Port-level checks of the integrator: fixed latency, identity result for zero norm and result ranges.
// ----------------------------------------------------------------------------
module qbri_checker #(
  parameter int QUAT_WIDTH = qbri_pkg::QUAT_WIDTH_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic signed [QUAT_WIDTH-1:0]     out_next_w,
  input logic signed [QUAT_WIDTH-1:0]     out_next_x,
  input logic signed [QUAT_WIDTH-1:0]     out_next_y,
  input logic signed [QUAT_WIDTH-1:0]     out_next_z,
  input logic                             out_degenerate
);

  localparam int LAT = 10 + 3 * QUAT_WIDTH;
  localparam logic signed [QUAT_WIDTH-1:0] ONE = QUAT_WIDTH'(1) << (QUAT_WIDTH - 2);

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LAT))
    else $error("result without accepted beat");

  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_next_w == ONE && out_next_x == '0 && out_next_y == '0 && out_next_z == '0))
    else $error("degenerate result is not identity");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_degenerate) |->
      (out_next_w <= ONE && out_next_w >= -ONE && out_next_x <= ONE && out_next_x >= -ONE &&
       out_next_y <= ONE && out_next_y >= -ONE && out_next_z <= ONE && out_next_z >= -ONE))
    else $error("normalized component out of range");

endmodule

bind quaternion_body_rate_integrator_core qbri_checker #(
  .QUAT_WIDTH (QUAT_WIDTH)
) u_qbri_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_next_w     (out_next_w),
  .out_next_x     (out_next_x),
  .out_next_y     (out_next_y),
  .out_next_z     (out_next_z),
  .out_degenerate (out_degenerate)
);
